/* rtl/gfq_pkg.sv */
package gfq_pkg;

  // Fixed field widths of the stream items and of the configuration register.
  localparam int IdW  = 14;
  localparam int GrpW = 4;
  localparam int LenW = 11;
  localparam int GcW  = 4;
  localparam int ActW = 2;
  localparam int StatW = 3;

  // Number of distinct ids that the id field can carry.
  localparam int IdSpan = 1 << IdW;

  // Group count after reset.
  localparam logic [GcW-1:0] GroupCountReset = 4'd10;

  typedef enum logic [ActW-1:0] {
    ACT_REG = 2'd0,
    ACT_ENQ = 2'd1,
    ACT_DEQ = 2'd2
  } gfq_action_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_DUP    = 3'd3,
    STAT_BADGRP = 3'd4
  } gfq_status_e;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_REDUCE = 3'd2,
    S_READ   = 3'd3,
    S_EXEC   = 3'd4
  } gfq_state_e;

  // One queue entry: the full id and the group that was fixed at enqueue.
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [GrpW-1:0] grp;
  } gfq_entry_t;

  // Broadcast control from the sequencer to every cell of the row.
  typedef struct packed {
    logic       ins;
    logic       del;
    gfq_entry_t fresh;
  } gfq_cell_ctrl_t;

  // One accepted input transaction.
  typedef struct packed {
    logic [ActW-1:0] act;
    logic [IdW-1:0]  id;
    logic [GrpW-1:0] grp;
  } gfq_item_t;

endpackage

/* rtl/gfq_ram.sv */
module gfq_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gfq_cell.sv */
module gfq_cell #(
  parameter int IDX   = 0,
  parameter int POS_W = 10
) (
  input  logic                    clk_i,
  input  gfq_pkg::gfq_cell_ctrl_t ctrl_i,
  input  logic [POS_W-1:0]        pos_i,
  input  gfq_pkg::gfq_entry_t     left_i,
  input  gfq_pkg::gfq_entry_t     right_i,
  output gfq_pkg::gfq_entry_t     entry_o
);

  localparam logic [POS_W-1:0] MyPos = POS_W'(IDX);

  gfq_pkg::gfq_entry_t entry_q;
  gfq_pkg::gfq_entry_t entry_d;

  // A pop moves every entry one place toward the head. An insert opens a gap
  // at the insert position: cells behind it take their left neighbor, the
  // cell at the position takes the new entry, and cells in front hold.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.del) begin
      entry_d = right_i;
    end else if (ctrl_i.ins) begin
      if (MyPos > pos_i) begin
        entry_d = left_i;
      end else if (MyPos == pos_i) begin
        entry_d = ctrl_i.fresh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* rtl/grouped_fifo_queue.sv */
// Team queue. Ids are registered as members of groups 1 to group_count; an
// enqueued id is placed right behind the last queued entry of its highest
// valid group, or at the tail when no entry of that group is queued or the
// id is unregistered. A dequeue pops the head. Every input transaction gives
// exactly one result transaction with the served id, a status code and the
// queue length after the operation. The queue is a row of QUEUE_DEPTH cells
// that shift in parallel; a small table of per-group entry counts and run
// ends gives the insert position without searching the row. Group membership
// lives in an ID_SPACE by MAX_GROUPS bit RAM with a registered read port.
// After reset the block sweeps that RAM to zero, one entry a cycle, and
// takes no input transaction until the sweep is done; configuration writes
// are taken at any time. With ID_SPACE of 16384 or more a transaction is
// accepted, which starts the membership read, and is then executed; no new
// one is taken until the last has executed. With a smaller ID_SPACE the id
// is first folded into the RAM range by one compare and subtract per cycle,
// and the membership read follows before the execute step. A result waits
// in an output register, and the next transaction is accepted while it
// waits; it stalls only at the execute step when the previous result has
// not yet been taken.
module grouped_fifo_queue #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int ID_SPACE    = 16384,
  parameter int MAX_GROUPS  = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: group_count.
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [13:0] member_id, [17:14] group, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [13:0] served_id, [24:14] queue_length, rest zero
  output logic [2:0]  m_axis_tuser   // [2:0] status
);

  localparam int IdW  = gfq_pkg::IdW;
  localparam int GrpW = gfq_pkg::GrpW;
  localparam int GcW  = gfq_pkg::GcW;
  localparam int LenW = gfq_pkg::LenW;

  localparam int PosW  = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SlotW = $clog2(ID_SPACE);
  localparam bit NeedMod = ID_SPACE < gfq_pkg::IdSpan;
  localparam int RedLast = NeedMod ? $clog2(gfq_pkg::IdSpan / ID_SPACE + 1) - 1 : 0;
  localparam int RedW = (RedLast > 0) ? $clog2(RedLast + 1) : 1;

  localparam logic [CntW-1:0]    DepthC    = CntW'(QUEUE_DEPTH);
  localparam logic [GcW-1:0]     MaxGrpC   = GcW'(MAX_GROUPS);
  localparam logic [SlotW-1:0]   SlotLastC = SlotW'(ID_SPACE - 1);
  localparam logic [RedW-1:0]    RedLastC  = RedW'(RedLast);

  // ---------------------------------------------------------------------
  // Registers.
  gfq_pkg::gfq_state_e  state_q, state_d;
  gfq_pkg::gfq_item_t   item_q;
  logic [SlotW-1:0]     clr_q;
  logic [GcW-1:0]       group_count_q;
  logic [IdW-1:0]       red_val_q;
  logic [RedW-1:0]      red_k_q;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      gcnt_q [MAX_GROUPS];
  logic [CntW-1:0]      gcnt_d [MAX_GROUPS];
  logic [CntW-1:0]      tail_q [MAX_GROUPS];
  logic [CntW-1:0]      tail_d [MAX_GROUPS];
  logic                 out_valid_q;
  logic [IdW-1:0]       out_id_q;
  gfq_pkg::gfq_status_e out_stat_q;
  logic [LenW-1:0]      out_len_q;

  // ---------------------------------------------------------------------
  // Combinational signals.
  logic                 in_accept;
  logic                 exec_fire;
  logic                 clearing;
  logic                 clr_last;
  logic [31:0]          red_mod;
  logic                 red_ge;
  logic [SlotW-1:0]     slot_cur;
  logic [SlotW-1:0]     ram_raddr;
  logic [SlotW-1:0]     ram_waddr;
  logic [MAX_GROUPS-1:0] ram_wdata;
  logic                 ram_we;
  logic [MAX_GROUPS-1:0] flags;
  logic [GcW-1:0]       lim;
  logic [GrpW-1:0]      look_g;
  logic [MAX_GROUPS-1:0] reg_bit;
  logic                 reg_bad;
  logic [GrpW-1:0]      sel_grp;
  logic [CntW-1:0]      sel_cnt;
  logic [CntW-1:0]      sel_tail;
  logic [PosW-1:0]      ins_pos;
  logic                 q_full;
  logic                 q_empty;
  logic                 do_ins;
  logic                 do_del;
  logic                 reg_wr;
  gfq_pkg::gfq_status_e status;
  logic [IdW-1:0]       served;
  gfq_pkg::gfq_cell_ctrl_t cell_ctrl;
  gfq_pkg::gfq_entry_t  ent [QUEUE_DEPTH];
  gfq_pkg::gfq_entry_t  head;

  assign clearing  = state_q == gfq_pkg::S_CLEAR;
  assign clr_last  = clr_q == SlotLastC;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign exec_fire = (state_q == gfq_pkg::S_EXEC) && (!out_valid_q || m_axis_tready);

  // ---------------------------------------------------------------------
  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfq_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer next state and input handshake.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      gfq_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_d = gfq_pkg::S_IDLE;
        end
      end
      gfq_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = NeedMod ? gfq_pkg::S_REDUCE : gfq_pkg::S_EXEC;
        end
      end
      gfq_pkg::S_REDUCE: begin
        if (red_k_q == '0) begin
          state_d = gfq_pkg::S_READ;
        end
      end
      gfq_pkg::S_READ: begin
        state_d = gfq_pkg::S_EXEC;
      end
      gfq_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_d = gfq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gfq_pkg::S_CLEAR;
      end
    endcase
  end

  // Membership sweep counter and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q         <= '0;
      group_count_q <= gfq_pkg::GroupCountReset;
    end else begin
      if (clearing && !clr_last) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        group_count_q <= cfg_wdata_i;
      end
    end
  end

  // Accepted transaction, held until it has executed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.act <= s_axis_tuser;
      item_q.id  <= s_axis_tdata[13:0];
      item_q.grp <= s_axis_tdata[17:14];
    end
  end

  // Id folding into the RAM range: one compare and subtract of a shifted
  // ID_SPACE per cycle, largest shift first.
  assign red_mod = 32'(ID_SPACE) << red_k_q;
  assign red_ge  = 32'(red_val_q) >= red_mod;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      red_val_q <= s_axis_tdata[13:0];
      red_k_q   <= RedLastC;
    end else if (state_q == gfq_pkg::S_REDUCE) begin
      if (red_ge) begin
        red_val_q <= red_val_q - IdW'(red_mod);
      end
      if (red_k_q != '0) begin
        red_k_q <= red_k_q - 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Membership RAM. The read starts in the accept cycle when no folding is
  // needed, so the flags are ready in the execute cycle.
  assign slot_cur  = NeedMod ? SlotW'(red_val_q) : SlotW'(item_q.id);
  assign ram_raddr = (state_q == gfq_pkg::S_IDLE) ? SlotW'(s_axis_tdata[13:0]) : slot_cur;
  assign ram_we    = clearing || (exec_fire && reg_wr);
  assign ram_waddr = clearing ? clr_q : slot_cur;
  assign ram_wdata = clearing ? '0 : (flags | reg_bit);

  gfq_ram #(
    .WIDTH (MAX_GROUPS),
    .DEPTH (ID_SPACE)
  ) u_members (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (flags)
  );

  // ---------------------------------------------------------------------
  // Group lookup: the highest flagged group that is valid under the limit.
  always_comb begin
    lim     = (group_count_q > MaxGrpC) ? MaxGrpC : group_count_q;
    look_g  = '0;
    reg_bit = '0;
    for (int h = 0; h < MAX_GROUPS; h++) begin
      if (flags[h] && (GcW'(h + 1) <= lim)) begin
        look_g = GrpW'(h + 1);
      end
      reg_bit[h] = item_q.grp == GrpW'(h + 1);
    end
    reg_bad = (item_q.grp == '0) || (GcW'(item_q.grp) > lim);
  end

  // Per-group table read at one group: the head's on a pop, else the
  // looked-up group.
  assign head    = ent[0];
  assign sel_grp = (item_q.act == gfq_pkg::ACT_DEQ) ? head.grp : look_g;

  always_comb begin
    sel_cnt  = '0;
    sel_tail = '0;
    for (int h = 0; h < MAX_GROUPS; h++) begin
      if (sel_grp == GrpW'(h + 1)) begin
        sel_cnt  = gcnt_q[h];
        sel_tail = tail_q[h];
      end
    end
  end

  // Insert right behind the group's run when it has queued entries.
  assign ins_pos = ((look_g != '0) && (sel_cnt != '0)) ? PosW'(sel_tail) : PosW'(count_q);
  assign q_full  = count_q >= DepthC;
  assign q_empty = count_q == '0;

  // Operation decode.
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    reg_wr = 1'b0;
    status = gfq_pkg::STAT_OK;
    served = '0;
    unique case (gfq_pkg::gfq_action_e'(item_q.act))
      gfq_pkg::ACT_REG: begin
        if (reg_bad) begin
          status = gfq_pkg::STAT_BADGRP;
        end else if ((flags & reg_bit) != '0) begin
          status = gfq_pkg::STAT_DUP;
        end else begin
          reg_wr = 1'b1;
        end
      end
      gfq_pkg::ACT_ENQ: begin
        if (q_full) begin
          status = gfq_pkg::STAT_FULL;
        end else begin
          do_ins = exec_fire;
        end
      end
      gfq_pkg::ACT_DEQ: begin
        if (q_empty) begin
          status = gfq_pkg::STAT_EMPTY;
        end else begin
          do_del = exec_fire;
          served = head.id;
        end
      end
      default: begin
        status = gfq_pkg::STAT_OK;
      end
    endcase
  end

  // Length and per-group table updates. Entries at or behind the insert
  // position move back one place, so run ends past it grow by one.
  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_del) begin
      count_d = count_q - 1'b1;
    end
    for (int h = 0; h < MAX_GROUPS; h++) begin
      gcnt_d[h] = gcnt_q[h];
      tail_d[h] = tail_q[h];
      if (do_ins) begin
        if (look_g == GrpW'(h + 1)) begin
          gcnt_d[h] = gcnt_q[h] + 1'b1;
          tail_d[h] = CntW'(ins_pos) + 1'b1;
        end else if (tail_q[h] > CntW'(ins_pos)) begin
          tail_d[h] = tail_q[h] + 1'b1;
        end
      end else if (do_del) begin
        if (gcnt_q[h] != '0) begin
          tail_d[h] = tail_q[h] - 1'b1;
        end
        if (head.grp == GrpW'(h + 1)) begin
          gcnt_d[h] = gcnt_q[h] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int h = 0; h < MAX_GROUPS; h++) begin
        gcnt_q[h] <= '0;
        tail_q[h] <= '0;
      end
    end else begin
      count_q <= count_d;
      for (int h = 0; h < MAX_GROUPS; h++) begin
        gcnt_q[h] <= gcnt_d[h];
        tail_q[h] <= tail_d[h];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Row of queue cells, head at cell 0.
  assign cell_ctrl.ins       = do_ins;
  assign cell_ctrl.del       = do_del;
  assign cell_ctrl.fresh.id  = item_q.id;
  assign cell_ctrl.fresh.grp = look_g;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    gfq_pkg::gfq_entry_t left_ent;
    gfq_pkg::gfq_entry_t right_ent;

    if (i == 0) begin : g_first
      assign left_ent = '0;
    end else begin : g_inner_l
      assign left_ent = ent[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner_r
      assign right_ent = ent[i+1];
    end

    gfq_cell #(
      .IDX   (i),
      .POS_W (PosW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .pos_i   (ins_pos),
      .left_i  (left_ent),
      .right_i (right_ent),
      .entry_o (ent[i])
    );
  end

  // ---------------------------------------------------------------------
  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_id_q   <= served;
      out_stat_q <= status;
      out_len_q  <= LenW'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_len_q, out_id_q};
  assign m_axis_tuser  = out_stat_q;

  // ---------------------------------------------------------------------
  // Assertions.

  // Only one transaction is in flight: after an accept, input stays closed.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  // An execute step changes the queue length by at most one entry.
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> (count_q == $past(count_q)) ||
                  (count_q == CntW'($past(count_q) + 1'b1)) ||
                  (count_q == CntW'($past(count_q) - 1'b1)))
    else $error("queue length jumped by more than one entry");

  // An empty-queue result always reports a length of zero and no id.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_stat_q == gfq_pkg::STAT_EMPTY)) |->
      ((out_len_q == '0) && (out_id_q == '0)))
    else $error("empty status with nonzero length or id");

endmodule

/* bench/testbench.sv */
module testbench;

  localparam int QueueDepth = 1024;
  localparam int MaxGroups  = 10;
  localparam int IdW        = gfq_pkg::IdW;
  localparam int GrpW       = gfq_pkg::GrpW;
  localparam int LenW       = gfq_pkg::LenW;
  localparam int GcW        = gfq_pkg::GcW;
  localparam int ActW       = gfq_pkg::ActW;
  localparam int IdSpan     = gfq_pkg::IdSpan;
  localparam logic [ActW-1:0] ActSpare = 2'd3;

  // What one result transaction should carry.
  typedef struct packed {
    logic [IdW-1:0]       served;
    gfq_pkg::gfq_status_e status;
    logic [LenW-1:0]      len;
  } outcome_t;

  // One row of the directed script; pinned rows carry their result by hand.
  typedef struct packed {
    logic [ActW-1:0]      act;
    logic [IdW-1:0]       id;
    logic [GrpW-1:0]      grp;
    logic                 pinned;
    logic [IdW-1:0]       served;
    gfq_pkg::gfq_status_e status;
    logic [LenW-1:0]      len;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'd0;
  logic [1:0]  s_axis_tuser = 2'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  grouped_fifo_queue #(
    .QUEUE_DEPTH(QueueDepth),
    .ID_SPACE   (IdSpan),
    .MAX_GROUPS (MaxGroups)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the team queue.
  logic [GcW-1:0]       group_count_m = gfq_pkg::GroupCountReset;
  bit [MaxGroups-1:0]   pair_flags [IdSpan];
  logic [IdW-1:0]       line_ids [$];
  logic [GrpW-1:0]      line_grps [$];
  outcome_t             outcome_fifo [$];
  int                   err_count = 0;

  // Hand-written result for the transaction currently offered.
  logic     pin_on = 1'b0;
  outcome_t pin_outcome = '0;

  // Sender pacing.
  int burst_left = 0;

  // Applies one request to the shadow state and returns its result.
  function automatic outcome_t team_queue_step(gfq_pkg::gfq_item_t req);
    outcome_t        r;
    int unsigned     lim;
    int              pos;
    int              k;
    logic [GrpW-1:0] g;
    lim = (group_count_m > MaxGroups) ? MaxGroups : group_count_m;
    r.served = '0;
    r.status = gfq_pkg::STAT_OK;
    case (req.act)
      gfq_pkg::ACT_REG: begin
        if (req.grp == 0 || req.grp > lim) begin
          r.status = gfq_pkg::STAT_BADGRP;
        end else if (pair_flags[req.id][req.grp-1]) begin
          r.status = gfq_pkg::STAT_DUP;
        end else begin
          pair_flags[req.id][req.grp-1] = 1'b1;
        end
      end
      gfq_pkg::ACT_ENQ: begin
        if (line_ids.size() >= QueueDepth) begin
          r.status = gfq_pkg::STAT_FULL;
        end else begin
          // Highest group that is valid under the current group count.
          g = '0;
          k = lim;
          while (k > 0 && g == 0) begin
            if (pair_flags[req.id][k-1]) g = GrpW'(k);
            k--;
          end
          // Behind the last queued member of that group, else at the tail.
          pos = line_ids.size();
          if (g != 0) begin
            for (k = line_ids.size(); k > 0; k--) begin
              if (line_grps[k-1] == g) begin
                pos = k;
                break;
              end
            end
          end
          line_ids.insert(pos, req.id);
          line_grps.insert(pos, g);
        end
      end
      gfq_pkg::ACT_DEQ: begin
        if (line_ids.size() == 0) begin
          r.status = gfq_pkg::STAT_EMPTY;
        end else begin
          r.served = line_ids.pop_front();
          void'(line_grps.pop_front());
        end
      end
      default: ;
    endcase
    r.len = LenW'(line_ids.size());
    return r;
  endfunction

  // Random request: mostly a small id pool so that groups cluster in the line.
  function automatic gfq_pkg::gfq_item_t random_request(int deq_w, int reg_w);
    gfq_pkg::gfq_item_t req;
    int unsigned        roll;
    int unsigned        lim;
    lim = (group_count_m > MaxGroups) ? MaxGroups : group_count_m;
    roll = $urandom_range(99);
    if (roll < 2) req.act = ActSpare;
    else if (roll < 2 + reg_w) req.act = gfq_pkg::ACT_REG;
    else if (roll < 2 + reg_w + deq_w) req.act = gfq_pkg::ACT_DEQ;
    else req.act = gfq_pkg::ACT_ENQ;
    roll = $urandom_range(99);
    if (roll < 80) req.id = IdW'($urandom_range(23));
    else if (roll < 92) req.id = IdW'($urandom);
    else if (roll < 96) req.id = '1;
    else req.id = '0;
    if (lim > 0 && $urandom_range(99) < 75) req.grp = GrpW'($urandom_range(lim, 1));
    else req.grp = GrpW'($urandom_range(15));
    return req;
  endfunction

  // Request monitor and result checker, both at the rising edge.
  always @(posedge clk_i) begin
    outcome_t           want;
    gfq_pkg::gfq_item_t seen;
    if (cfg_we_i) group_count_m = cfg_wdata_i;
    if (m_axis_tvalid && m_axis_tready) begin
      if (outcome_fifo.size() == 0) begin
        err_count++;
        $display("%0t: result transaction with none expected, got data %0h status %0d",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = outcome_fifo.pop_front();
        if (m_axis_tdata[13:0] !== want.served) begin
          err_count++;
          $display("%0t: served_id expected %0d got %0d", $time, want.served,
                   m_axis_tdata[13:0]);
        end
        if (m_axis_tuser !== want.status) begin
          err_count++;
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   m_axis_tuser);
        end
        if (m_axis_tdata[24:14] !== want.len) begin
          err_count++;
          $display("%0t: queue_length expected %0d got %0d", $time, want.len,
                   m_axis_tdata[24:14]);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      seen.act = s_axis_tuser;
      seen.id  = s_axis_tdata[13:0];
      seen.grp = s_axis_tdata[17:14];
      want = team_queue_step(seen);
      outcome_fifo.push_back(pin_on ? pin_outcome : want);
    end
  end

  // Receiver back-pressure: modes of always ready, coin flip and rare ready.
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(2);
      stall_left = $urandom_range(300, 40);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(1));
      default: m_axis_tready <= ($urandom_range(5) == 0);
    endcase
  end

  // Drops tvalid and idles the sender for a time set by n.
  task automatic pause_sender(int n);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Offers one request, with bursts and gaps, and waits for its transaction.
  task automatic send_request(gfq_pkg::gfq_item_t req, logic pinned,
                              outcome_t pinned_out);
    if (burst_left == 0) begin
      pause_sender($urandom_range(6, 1));
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(120, 40) : $urandom_range(20, 1);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, req.grp, req.id};
    s_axis_tuser  <= req.act;
    pin_on        <= pinned;
    pin_outcome   <= pinned_out;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Lets every outstanding result arrive.
  task automatic drain_results();
    pause_sender(1);
    while (outcome_fifo.size() != 0) @(posedge clk_i);
  endtask

  // Writes group_count once the block has gone idle.
  task automatic write_group_count(logic [3:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random mix; now and then the sender holds off until the line is quiet.
  task automatic run_mix(int count, int deq_w, int reg_w);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) == 0) drain_results();
      send_request(random_request(deq_w, reg_w), 1'b0, '0);
    end
  endtask

  script_row_t script [23];

  initial begin
    gfq_pkg::gfq_item_t req;
    outcome_t           pinned_out;
    // Group count is 10 out of reset. Error codes and the first result after
    // reset are pinned; the other rows go through the shadow model.
    script = '{
      '{gfq_pkg::ACT_DEQ, 14'd0,     4'd0,  1'b1, 14'd0, gfq_pkg::STAT_EMPTY,  11'd0},
      '{gfq_pkg::ACT_REG, 14'd5,     4'd0,  1'b1, 14'd0, gfq_pkg::STAT_BADGRP, 11'd0},
      '{gfq_pkg::ACT_REG, 14'd5,     4'd11, 1'b1, 14'd0, gfq_pkg::STAT_BADGRP, 11'd0},
      '{gfq_pkg::ACT_REG, 14'd5,     4'd15, 1'b1, 14'd0, gfq_pkg::STAT_BADGRP, 11'd0},
      '{gfq_pkg::ACT_REG, 14'd5,     4'd10, 1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_REG, 14'd5,     4'd10, 1'b1, 14'd0, gfq_pkg::STAT_DUP,    11'd0},
      '{gfq_pkg::ACT_REG, 14'd16383, 4'd1,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_REG, 14'd16383, 4'd3,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_REG, 14'd0,     4'd3,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_ENQ, 14'd100,   4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_ENQ, 14'd16383, 4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_ENQ, 14'd5,     4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_ENQ, 14'd0,     4'd15, 1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_ENQ, 14'd100,   4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{ActSpare,         14'd16383, 4'd15, 1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_DEQ, 14'd16383, 4'd15, 1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_DEQ, 14'd0,     4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_ENQ, 14'd5,     4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_DEQ, 14'd0,     4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_DEQ, 14'd0,     4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_DEQ, 14'd0,     4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_DEQ, 14'd0,     4'd0,  1'b0, 14'd0, gfq_pkg::STAT_OK,     11'd0},
      '{gfq_pkg::ACT_DEQ, 14'd0,     4'd0,  1'b1, 14'd0, gfq_pkg::STAT_EMPTY,  11'd0}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed script.
    foreach (script[i]) begin
      req = '{act: script[i].act, id: script[i].id, grp: script[i].grp};
      pinned_out = '{served: script[i].served, status: script[i].status,
                     len: script[i].len};
      send_request(req, script[i].pinned, pinned_out);
    end

    // Balanced mix at a middle group count.
    write_group_count(4'd7);
    run_mix(80, 25, 25);

    // Fill the line to capacity under a small group count, then push past it.
    write_group_count(4'd4);
    while (line_ids.size() < QueueDepth) send_request(random_request(0, 10), 1'b0, '0);
    for (int n = 0; n < 8; n++) send_request(random_request(15, 15), 1'b0, '0);

    // Count above the group maximum: the limit clamps to ten.
    write_group_count(4'd15);
    run_mix(90, 45, 20);

    // No valid group at all.
    write_group_count(4'd0);
    run_mix(30, 30, 30);

    // Single group.
    write_group_count(4'd1);
    run_mix(100, 40, 15);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: covers the membership sweep after reset with a wide margin.
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
